FILE: rtl/core/ttb_pkg.sv
// Shared types, constants and microprogram for the text terminal buffer.
package ttb_pkg;

    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_LINES_DEF   = 16;

    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] RETURN_CODE  = 8'h0D;

    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [7:0] CFG_ACTIVE_COLUMNS = 8'd0;
    localparam logic [7:0] CFG_ACTIVE_LINES   = 8'd1;

    localparam int CFG_DATA_W = 7;
    localparam logic [6:0] ACTIVE_COLUMNS_RST = 7'd64;
    localparam logic [4:0] ACTIVE_LINES_RST   = 5'd16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] char_code;
        logic [7:0] col;
        logic [7:0] row;
    } in_item_t;

    typedef struct packed {
        logic [7:0] cell_data;
        logic [5:0] cursor_col;
        logic [3:0] cursor_row;
        logic       changed;
        logic       scroll_pending;
    } out_item_t;

    // Datapath operations, one per microinstruction.
    typedef enum logic [3:0] {
        OP_NOP        = 4'd0,
        OP_ACCEPT     = 4'd1,
        OP_EMIT       = 4'd2,
        OP_IDX_ZERO   = 4'd3,
        OP_FILL       = 4'd4,
        OP_RD_SRC     = 4'd5,
        OP_WR_MOVE    = 4'd6,
        OP_WRITE_CHAR = 4'd7,
        OP_CTRL_MOVE  = 4'd8,
        OP_SET_CURSOR = 4'd9,
        OP_CLEAR_DONE = 4'd10,
        OP_RD_CELL    = 4'd11,
        OP_READ_DONE  = 4'd12
    } op_t;

    // Jump conditions; C_NEXT never jumps.
    typedef enum logic [3:0] {
        C_NEXT        = 4'd0,
        C_ALWAYS      = 4'd1,
        C_NO_ITEM     = 4'd2,
        C_CMD_PUT     = 4'd3,
        C_CMD_SET     = 4'd4,
        C_CMD_CLR     = 4'd5,
        C_CODE_NUL    = 4'd6,
        C_CODE_MOVE   = 4'd7,
        C_NO_PEND     = 4'd8,
        C_AT_MOVE_END = 4'd9,
        C_FILL_MORE   = 4'd10,
        C_BLANK_MORE  = 4'd11,
        C_OUT_BUSY    = 4'd12
    } cond_t;

    typedef struct packed {
        logic no_item;
        logic cmd_put;
        logic cmd_set;
        logic cmd_clr;
        logic code_nul;
        logic code_move;
        logic no_pend;
        logic at_move_end;
        logic fill_more;
        logic blank_more;
        logic out_busy;
    } flags_t;

    localparam int UPC_W = 5;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    localparam logic [UPC_W-1:0] STEP_EMIT      = 5'd0;
    localparam logic [UPC_W-1:0] STEP_IDLE      = 5'd1;
    localparam logic [UPC_W-1:0] STEP_DISP_PUT  = 5'd2;
    localparam logic [UPC_W-1:0] STEP_DISP_SET  = 5'd3;
    localparam logic [UPC_W-1:0] STEP_DISP_CLR  = 5'd4;
    localparam logic [UPC_W-1:0] STEP_READ      = 5'd5;
    localparam logic [UPC_W-1:0] STEP_READ_DONE = 5'd6;
    localparam logic [UPC_W-1:0] STEP_SET       = 5'd7;
    localparam logic [UPC_W-1:0] STEP_CLR       = 5'd8;
    localparam logic [UPC_W-1:0] STEP_CLR_FILL  = 5'd9;
    localparam logic [UPC_W-1:0] STEP_CLR_DONE  = 5'd10;
    localparam logic [UPC_W-1:0] STEP_PUT       = 5'd11;
    localparam logic [UPC_W-1:0] STEP_PUT_CTRL  = 5'd12;
    localparam logic [UPC_W-1:0] STEP_PUT_PEND  = 5'd13;
    localparam logic [UPC_W-1:0] STEP_SCROLL    = 5'd14;
    localparam logic [UPC_W-1:0] STEP_MOVE_TEST = 5'd15;
    localparam logic [UPC_W-1:0] STEP_MOVE_RD   = 5'd16;
    localparam logic [UPC_W-1:0] STEP_MOVE_WR   = 5'd17;
    localparam logic [UPC_W-1:0] STEP_BLANK     = 5'd18;
    localparam logic [UPC_W-1:0] STEP_WRITE     = 5'd19;
    localparam logic [UPC_W-1:0] STEP_CTRL      = 5'd20;
    localparam logic [UPC_W-1:0] STEP_RESET     = 5'd21;
    localparam logic [UPC_W-1:0] STEP_RST_FILL  = 5'd22;
    localparam logic [UPC_W-1:0] STEP_RST_DONE  = 5'd23;

    // Microprogram ROM: jump to target when cond holds, else fall through.
    function automatic uword_t ucode_word(input logic [UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            STEP_EMIT:      w = '{op: OP_EMIT,       cond: C_OUT_BUSY,    target: STEP_EMIT};
            STEP_IDLE:      w = '{op: OP_ACCEPT,     cond: C_NO_ITEM,     target: STEP_IDLE};
            STEP_DISP_PUT:  w = '{op: OP_NOP,        cond: C_CMD_PUT,     target: STEP_PUT};
            STEP_DISP_SET:  w = '{op: OP_NOP,        cond: C_CMD_SET,     target: STEP_SET};
            STEP_DISP_CLR:  w = '{op: OP_NOP,        cond: C_CMD_CLR,     target: STEP_CLR};
            STEP_READ:      w = '{op: OP_RD_CELL,    cond: C_NEXT,        target: STEP_EMIT};
            STEP_READ_DONE: w = '{op: OP_READ_DONE,  cond: C_ALWAYS,      target: STEP_EMIT};
            STEP_SET:       w = '{op: OP_SET_CURSOR, cond: C_ALWAYS,      target: STEP_EMIT};
            STEP_CLR:       w = '{op: OP_IDX_ZERO,   cond: C_NEXT,        target: STEP_EMIT};
            STEP_CLR_FILL:  w = '{op: OP_FILL,       cond: C_FILL_MORE,   target: STEP_CLR_FILL};
            STEP_CLR_DONE:  w = '{op: OP_CLEAR_DONE, cond: C_ALWAYS,      target: STEP_EMIT};
            STEP_PUT:       w = '{op: OP_NOP,        cond: C_CODE_NUL,    target: STEP_EMIT};
            STEP_PUT_CTRL:  w = '{op: OP_NOP,        cond: C_CODE_MOVE,   target: STEP_CTRL};
            STEP_PUT_PEND:  w = '{op: OP_NOP,        cond: C_NO_PEND,     target: STEP_WRITE};
            STEP_SCROLL:    w = '{op: OP_IDX_ZERO,   cond: C_NEXT,        target: STEP_EMIT};
            STEP_MOVE_TEST: w = '{op: OP_NOP,        cond: C_AT_MOVE_END, target: STEP_BLANK};
            STEP_MOVE_RD:   w = '{op: OP_RD_SRC,     cond: C_NEXT,        target: STEP_EMIT};
            STEP_MOVE_WR:   w = '{op: OP_WR_MOVE,    cond: C_ALWAYS,      target: STEP_MOVE_TEST};
            STEP_BLANK:     w = '{op: OP_FILL,       cond: C_BLANK_MORE,  target: STEP_BLANK};
            STEP_WRITE:     w = '{op: OP_WRITE_CHAR, cond: C_ALWAYS,      target: STEP_EMIT};
            STEP_CTRL:      w = '{op: OP_CTRL_MOVE,  cond: C_ALWAYS,      target: STEP_EMIT};
            STEP_RESET:     w = '{op: OP_IDX_ZERO,   cond: C_NEXT,        target: STEP_IDLE};
            STEP_RST_FILL:  w = '{op: OP_FILL,       cond: C_FILL_MORE,   target: STEP_RST_FILL};
            STEP_RST_DONE:  w = '{op: OP_NOP,        cond: C_ALWAYS,      target: STEP_IDLE};
            default:        w = '{op: OP_NOP,        cond: C_ALWAYS,      target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/core/ttb_useq.sv
// Microprogram sequencer: step counter, control ROM and jump selection.
module ttb_useq
    import ttb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  flags_t flags,
    output op_t    op
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    uword_t           word;
    logic             take;

    assign word = ucode_word(upc_reg);
    assign op   = word.op;

    always_comb begin
        case (word.cond)
            C_NEXT:        take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_ITEM:     take = flags.no_item;
            C_CMD_PUT:     take = flags.cmd_put;
            C_CMD_SET:     take = flags.cmd_set;
            C_CMD_CLR:     take = flags.cmd_clr;
            C_CODE_NUL:    take = flags.code_nul;
            C_CODE_MOVE:   take = flags.code_move;
            C_NO_PEND:     take = flags.no_pend;
            C_AT_MOVE_END: take = flags.at_move_end;
            C_FILL_MORE:   take = flags.fill_more;
            C_BLANK_MORE:  take = flags.blank_more;
            C_OUT_BUSY:    take = flags.out_busy;
            default:       take = 1'b0;
        endcase
        upc_next = take ? word.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= STEP_RESET;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

FILE: rtl/core/ttb_datapath.sv
// Datapath: cursor, flags, config registers, cell memory and result register.
module ttb_datapath
    import ttb_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_LINES   = MAX_LINES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  op_t                   op,
    output flags_t                flags,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int ECW   = $clog2(MAX_COLUMNS + 1);
    localparam int ERW   = $clog2(MAX_LINES + 1);
    localparam int CELLS = MAX_COLUMNS * MAX_LINES;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [AW-1:0] FILL_LAST = AW'(CELLS - 1);

    logic [6:0]    acol_reg;
    logic [4:0]    alin_reg;
    in_item_t      item_reg,    item_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic          pend_reg,    pend_next;
    logic          dirty_reg,   dirty_next;
    logic [AW-1:0] idx_reg,     idx_next;
    logic [7:0]    data_reg,    data_next;
    logic          m_valid_reg, m_valid_next;
    out_item_t     m_data_reg,  m_data_next;

    logic [7:0]    cells_mem [CELLS];
    logic [7:0]    rd_q;
    logic          mem_we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          rd_en;
    logic [AW-1:0] raddr;

    logic [ECW-1:0] eff_cols;
    logic [ERW-1:0] eff_lines;
    logic [CW-1:0]  item_col_c, cur_col_c;
    logic [RW-1:0]  item_row_c, cur_row_c;
    logic [AW-1:0]  cur_addr, item_addr, src_addr, move_end, blank_last;
    logic [8:0]     col_inc;
    logic           col_wrap;
    logic [6:0]     row_inc;
    logic           row_ovf;
    logic [7:0]     put_code;
    logic           out_busy;

    // Register values outside 1..MAX act as the nearest bound.
    always_comb begin
        if (acol_reg == 7'd0) begin
            eff_cols = ECW'(1);
        end else if (9'(acol_reg) > 9'(MAX_COLUMNS)) begin
            eff_cols = ECW'(MAX_COLUMNS);
        end else begin
            eff_cols = ECW'(acol_reg);
        end
        if (alin_reg == 5'd0) begin
            eff_lines = ERW'(1);
        end else if (7'(alin_reg) > 7'(MAX_LINES)) begin
            eff_lines = ERW'(MAX_LINES);
        end else begin
            eff_lines = ERW'(alin_reg);
        end
    end

    assign item_col_c = (9'(item_reg.col) >= 9'(eff_cols)) ?
                        CW'(9'(eff_cols) - 9'd1) : CW'(item_reg.col);
    assign item_row_c = (9'(item_reg.row) >= 9'(eff_lines)) ?
                        RW'(9'(eff_lines) - 9'd1) : RW'(item_reg.row);
    assign cur_col_c  = (9'(cur_col_reg) >= 9'(eff_cols)) ?
                        CW'(9'(eff_cols) - 9'd1) : cur_col_reg;
    assign cur_row_c  = (9'(cur_row_reg) >= 9'(eff_lines)) ?
                        RW'(9'(eff_lines) - 9'd1) : cur_row_reg;

    assign cur_addr   = AW'(int'(cur_row_reg) * MAX_COLUMNS + int'(cur_col_reg));
    assign item_addr  = AW'(int'(item_row_c) * MAX_COLUMNS + int'(item_col_c));
    assign src_addr   = AW'(int'(idx_reg) + MAX_COLUMNS);
    // scroll copies lines 1..n-1 up, then blanks line n-1
    assign move_end   = AW'((int'(eff_lines) - 1) * MAX_COLUMNS);
    assign blank_last = AW'(int'(eff_lines) * MAX_COLUMNS - 1);

    assign col_inc  = 9'(cur_col_reg) + 9'd1;
    assign col_wrap = col_inc >= 9'(eff_cols);
    assign row_inc  = 7'(cur_row_reg) + 7'd1;
    assign row_ovf  = row_inc >= 7'(eff_lines);
    assign put_code = (item_reg.char_code < SPACE_CODE) ? SPACE_CODE : item_reg.char_code;
    assign out_busy = m_valid_reg && !m_ready;

    assign flags = '{
        no_item:     !s_valid,
        cmd_put:     item_reg.cmd == CMD_PUT,
        cmd_set:     item_reg.cmd == CMD_SET,
        cmd_clr:     item_reg.cmd == CMD_CLEAR,
        code_nul:    item_reg.char_code == 8'd0,
        code_move:   (item_reg.char_code == NEWLINE_CODE) ||
                     (item_reg.char_code == RETURN_CODE),
        no_pend:     !pend_reg,
        at_move_end: idx_reg == move_end,
        fill_more:   idx_reg != FILL_LAST,
        blank_more:  idx_reg != blank_last,
        out_busy:    out_busy
    };

    assign s_ready   = (op == OP_ACCEPT);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        item_next    = item_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        pend_next    = pend_reg;
        dirty_next   = dirty_reg;
        idx_next     = idx_reg;
        data_next    = data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        waddr        = idx_reg;
        wdata        = SPACE_CODE;
        rd_en        = 1'b0;
        raddr        = item_addr;
        case (op)
            OP_ACCEPT: begin
                if (s_valid) begin
                    item_next    = s_data;
                    data_next    = 8'd0;
                    cur_col_next = cur_col_c;
                    cur_row_next = cur_row_c;
                end
            end
            OP_IDX_ZERO: begin
                idx_next = '0;
            end
            OP_FILL: begin
                mem_we   = 1'b1;
                idx_next = idx_reg + 1'b1;
            end
            OP_RD_SRC: begin
                rd_en = 1'b1;
                raddr = src_addr;
            end
            OP_WR_MOVE: begin
                mem_we   = 1'b1;
                wdata    = rd_q;
                idx_next = idx_reg + 1'b1;
            end
            OP_WRITE_CHAR: begin
                mem_we     = 1'b1;
                waddr      = cur_addr;
                wdata      = put_code;
                dirty_next = 1'b1;
                pend_next  = 1'b0;
                if (col_wrap) begin
                    cur_col_next = '0;
                    if (row_ovf) begin
                        pend_next = 1'b1;
                    end else begin
                        cur_row_next = RW'(row_inc);
                    end
                end else begin
                    cur_col_next = CW'(col_inc);
                end
            end
            OP_CTRL_MOVE: begin
                cur_col_next = '0;
                if (item_reg.char_code == NEWLINE_CODE) begin
                    if (row_ovf) begin
                        pend_next = 1'b1;
                    end else begin
                        cur_row_next = RW'(row_inc);
                    end
                end
            end
            OP_SET_CURSOR: begin
                cur_col_next = item_col_c;
                cur_row_next = item_row_c;
                pend_next    = 1'b0;
            end
            OP_CLEAR_DONE: begin
                cur_col_next = '0;
                cur_row_next = '0;
                pend_next    = 1'b0;
                dirty_next   = 1'b1;
            end
            OP_RD_CELL: begin
                rd_en = 1'b1;
            end
            OP_READ_DONE: begin
                data_next  = rd_q;
                dirty_next = 1'b0;
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{
                        cell_data:      data_reg,
                        cursor_col:     6'(cur_col_reg),
                        cursor_row:     4'(cur_row_reg),
                        changed:        dirty_reg,
                        scroll_pending: pend_reg
                    };
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cells_mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rd_q <= cells_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acol_reg    <= ACTIVE_COLUMNS_RST;
            alin_reg    <= ACTIVE_LINES_RST;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            pend_reg    <= 1'b0;
            dirty_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && (cfg_index == CFG_ACTIVE_COLUMNS)) begin
                acol_reg <= 7'(cfg_data);
            end
            if (cfg_valid && (cfg_index == CFG_ACTIVE_LINES)) begin
                alin_reg <= 5'(cfg_data);
            end
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            pend_reg    <= pend_next;
            dirty_reg   <= dirty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        idx_reg    <= idx_next;
        data_reg   <= data_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: rtl/core/text_terminal_buffer.sv
// Character-cell text buffer with cursor and deferred scroll, microcoded.
//
// Commands arrive on s_valid/s_ready/s_data (put character, set cursor,
// clear, read cell); each transaction yields exactly one result on
// m_valid/m_ready/m_data with the cursor, changed and scroll flags.
// active_columns (index 0) and active_lines (index 1) are written on
// cfg_valid/cfg_ready; cfg_ready is always high.
// One item is handled at a time by a microprogram that steps through a
// single-port-write, single-port-read cell memory, one access per cycle.
// A printable put with a scroll pending first scrolls the active lines up
// and blanks the last one; clear fills all cells with spaces. s_ready
// rises at the edge that loads the result. After reset the block fills
// all MAX_COLUMNS*MAX_LINES cells with spaces while s_ready is low.
// A held result waits in the output register while m_ready is low; the
// next command may be accepted meanwhile, and its result waits until the
// register empties.
module text_terminal_buffer
    import ttb_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int MAX_LINES   = MAX_LINES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    flags_t flags;
    op_t    op;

    ttb_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .op      (op)
    );

    ttb_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_LINES   (MAX_LINES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .flags     (flags),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
